/* hdl/cbe_pkg.sv */
// cbe_pkg: shared widths, register indexes, reset values and the
// command/status types passed between the easing controller and datapath.
// No dependencies.
package cbe_pkg;

  localparam int PROG_W     = 17;
  localparam int XREG_W     = 17;
  localparam int YREG_W     = 19;
  localparam int OUT_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_X1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y2 = 3'd3;

  localparam logic [XREG_W-1:0] X1_RST = 17'd16384;
  localparam logic [YREG_W-1:0] Y1_RST = 19'd6554;
  localparam logic [XREG_W-1:0] X2_RST = 17'd16384;
  localparam logic [YREG_W-1:0] Y2_RST = 19'd65536;

  localparam int NEWTON_STEPS_DEF = 8;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int BISECT_STEPS_DEF = 20;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,
    DP_LOAD,
    DP_MAC,
    DP_ERR,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_NEWTON_UPD,
    DP_BIS_INIT,
    DP_BIS_UPD,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    CF_ZERO,
    CF_AX,
    CF_BX,
    CF_CX,
    CF_AY,
    CF_BY,
    CF_CY,
    CF_AX3,
    CF_BX2
  } coef_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_ACC
  } res_sel_t;

  typedef struct packed {
    dp_op_t    op;
    coef_sel_t coef;
    res_sel_t  res;
  } dp_cmd_t;

  typedef struct packed {
    logic t_zero;
    logic t_one;
    logic err_small_n;
    logic err_small_b;
    logic acc_small;
    logic lo_lt_hi;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/cbe_if.sv */
// cbe_if: valid/ready channel interfaces for progress in, eased out and
// configuration writes. Depends on cbe_pkg for payload widths.

interface cbe_req_if;
  logic                         valid;
  logic                         ready;
  logic [cbe_pkg::PROG_W-1:0]   progress;
  modport source (output valid, output progress, input ready);
  modport sink (input valid, input progress, output ready);
endinterface

interface cbe_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbe_pkg::OUT_W-1:0]  eased;
  modport source (output valid, output eased, input ready);
  modport sink (input valid, input eased, output ready);
endinterface

interface cbe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbe_pkg::CFG_IDX_W-1:0]    index;
  logic [cbe_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/cbe_datapath.sv */
// cbe_datapath: control point registers, curve coefficients, shared
// rounding multiplier, serial divider, bisection bounds and output register.
// Depends on cbe_pkg; driven by cbe_ctrl commands.
module cbe_datapath #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cbe_pkg::dp_cmd_t                    cmd,
  output cbe_pkg::dp_stat_t                   stat,
  input  logic [cbe_pkg::PROG_W-1:0]          progress,
  input  logic                                cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [cbe_pkg::OUT_W-1:0]    eased
);
  import cbe_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int CW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 6;
  localparam int AW = CW + 2;
  localparam int PW = AW + SW + 1;
  localparam int TW = (PROG_W > SW) ? PROG_W : SW;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint NTOL_R = (ONE + 500000) / 1000000;
  localparam longint NTOL = (NTOL_R < 1) ? 1 : NTOL_R;
  localparam longint BTOL_R = (ONE + 5000) / 10000;
  localparam longint BTOL = (BTOL_R < 1) ? 1 : BTOL_R;
  localparam longint OMAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OMIN = -(longint'(1) << (OUT_W - 1));

  localparam logic [SW-1:0]        ONE_S  = SW'(ONE);
  localparam logic [TW-1:0]        ONE_T  = TW'(ONE);
  localparam logic signed [CW-1:0] ONE_C  = CW'(ONE);
  localparam logic signed [AW-1:0] ONE_A  = AW'(ONE);
  localparam logic [AW-1:0]        NTOL_A = AW'(NTOL);
  localparam logic [AW-1:0]        BTOL_A = AW'(BTOL);
  localparam logic signed [AW-1:0] OMAX_A = AW'(OMAX);
  localparam logic signed [AW-1:0] OMIN_A = AW'(OMIN);
  localparam logic signed [PW-1:0] HALF_P = PW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW+1:0] TWO_Q  = (SW+2)'(longint'(2) << FRAC_BITS);
  localparam logic signed [SW+1:0] ONE_Q  = (SW+2)'(ONE);

  // control point registers
  logic [XREG_W-1:0] x1, x2;
  logic [YREG_W-1:0] y1, y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= X1_RST;
      y1 <= Y1_RST;
      x2 <= X2_RST;
      y2 <= Y2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X1:  x1 <= cfg_data[XREG_W-1:0];
        REG_Y1:  y1 <= cfg_data[YREG_W-1:0];
        REG_X2:  x2 <= cfg_data[XREG_W-1:0];
        REG_Y2:  y2 <= cfg_data[YREG_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients from the control points
  logic signed [CW-1:0] x1w, x2w, x1c, x2c, y1w, y2w;
  logic signed [CW-1:0] cx_n, bx_n, ax_n, cy_n, by_n, ay_n;

  always_comb begin
    x1w  = CW'(x1);
    x2w  = CW'(x2);
    x1c  = (x1w > ONE_C) ? ONE_C : x1w;
    x2c  = (x2w > ONE_C) ? ONE_C : x2w;
    y1w  = CW'(signed'(y1));
    y2w  = CW'(signed'(y2));
    cx_n = (x1c <<< 1) + x1c;
    bx_n = ((x2c - x1c) <<< 1) + (x2c - x1c) - cx_n;
    ax_n = ONE_C - cx_n - bx_n;
    cy_n = (y1w <<< 1) + y1w;
    by_n = ((y2w - y1w) <<< 1) + (y2w - y1w) - cy_n;
    ay_n = ONE_C - cy_n - by_n;
  end

  logic signed [CW-1:0] cx, bx, ax, cy, by, ay, ax3, bx2;
  logic [PROG_W-1:0]    t;
  logic [SW-1:0]        s, lo, hi;
  logic signed [AW-1:0] acc, err;
  logic [AW-1:0]        dv;
  logic [AW:0]          rem;
  logic [SW-1:0]        quo;
  logic                 sat, neg;

  logic signed [CW-1:0] cf;
  logic signed [AW-1:0] cfa, mq, mac, err_n, t_a, res_v, res_c;
  logic signed [PW-1:0] prod;
  logic [AW-1:0]        err_abs, acc_abs, rd;
  logic                 ge;
  logic signed [SW+1:0] qs, sn, snew;
  logic [SW-1:0]        s_clamp, lo_n, hi_n;
  logic [SW:0]          mid;

  always_comb begin
    case (cmd.coef)
      CF_AX:   cf = ax;
      CF_BX:   cf = bx;
      CF_CX:   cf = cx;
      CF_AY:   cf = ay;
      CF_BY:   cf = by;
      CF_CY:   cf = cy;
      CF_AX3:  cf = ax3;
      CF_BX2:  cf = bx2;
      default: cf = '0;
    endcase
    cfa = AW'(cf);

    // round to nearest, ties toward plus infinity
    prod = acc * $signed({1'b0, s});
    mq   = AW'((prod + HALF_P) >>> FRAC_BITS);
    mac  = mq + cfa;

    t_a     = AW'(t);
    err_n   = acc - t_a;
    err_abs = err[AW-1] ? AW'(-err) : AW'(err);
    acc_abs = acc[AW-1] ? AW'(-acc) : AW'(acc);

    ge = rem >= {1'b0, dv};
    rd = ge ? AW'(rem - {1'b0, dv}) : AW'(rem);

    // an oversized quotient only has to push s past either end
    qs   = sat ? TWO_Q : (SW+2)'(quo);
    sn   = (SW+2)'(s);
    snew = neg ? (sn + qs) : (sn - qs);
    if (snew < 0) s_clamp = '0;
    else if (snew > ONE_Q) s_clamp = ONE_S;
    else s_clamp = SW'(snew);

    lo_n = err[AW-1] ? s : lo;
    hi_n = err[AW-1] ? hi : s;
    mid  = ({1'b0, lo_n} + {1'b0, hi_n}) >> 1;

    case (cmd.res)
      RES_ONE: res_v = ONE_A;
      RES_ACC: res_v = acc;
      default: res_v = '0;
    endcase
    if (res_v > OMAX_A) res_c = OMAX_A;
    else if (res_v < OMIN_A) res_c = OMIN_A;
    else res_c = res_v;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        t   <= progress;
        s   <= SW'(progress);
        cx  <= cx_n;
        bx  <= bx_n;
        ax  <= ax_n;
        cy  <= cy_n;
        by  <= by_n;
        ay  <= ay_n;
        ax3 <= (ax_n <<< 1) + ax_n;
        bx2 <= bx_n <<< 1;
      end
      DP_LOAD: acc <= cfa;
      DP_MAC:  acc <= mac;
      DP_ERR:  err <= err_n;
      DP_DIV_INIT: begin
        dv  <= acc_abs;
        rem <= {1'b0, err_abs};
        quo <= '0;
        sat <= {1'b0, err_abs} >= {acc_abs, 1'b0};
        neg <= err[AW-1] ^ acc[AW-1];
      end
      DP_DIV_STEP: begin
        rem <= {rd, 1'b0};
        quo <= {quo[SW-2:0], ge};
      end
      DP_NEWTON_UPD: s <= s_clamp;
      DP_BIS_INIT: begin
        lo <= '0;
        hi <= ONE_S;
        s  <= SW'(t);
      end
      DP_BIS_UPD: begin
        lo <= lo_n;
        hi <= hi_n;
        s  <= mid[SW-1:0];
      end
      DP_FINISH: eased <= res_c[OUT_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (cmd.op == DP_FINISH) rsp_valid <= 1'b1;
    end
  end

  always_comb begin
    stat.t_zero      = (t == '0);
    stat.t_one       = (TW'(t) >= ONE_T);
    stat.err_small_n = (err_abs < NTOL_A);
    stat.err_small_b = (err_abs < BTOL_A);
    stat.acc_small   = (acc_abs < NTOL_A);
    stat.lo_lt_hi    = (lo < hi);
    stat.out_free    = !rsp_valid || rsp_ready;
  end

endmodule

/* hdl/cbe_ctrl.sv */
// cbe_ctrl: sequencer for the easing solver; steps the datapath through
// end checks, Newton steps, bisection and the final y evaluation.
// Depends on cbe_pkg.
module cbe_ctrl #(
  parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
  parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF,
  parameter int BISECT_STEPS = cbe_pkg::BISECT_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output cbe_pkg::dp_cmd_t   cmd,
  input  cbe_pkg::dp_stat_t  stat
);
  import cbe_pkg::*;

  localparam int SW  = FRAC_BITS + 1;
  localparam int DCW = $clog2(SW);
  localparam int NIW = $clog2(NEWTON_STEPS + 1);
  localparam int BIW = $clog2(BISECT_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ENDS, S_XPOLY, S_XERR, S_NCHK, S_DPOLY, S_DCHK, S_DIVI,
    S_DIVS, S_NUPD, S_BINIT, S_BLOOP, S_BCHK, S_BUPD, S_YPOLY, S_FIN
  } state_t;

  state_t          state;
  logic [1:0]      ph;
  logic [NIW-1:0]  ni;
  logic [BIW-1:0]  bi;
  logic [DCW-1:0]  dc;
  logic            bis;
  res_sel_t        res_sel;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.coef = CF_ZERO;
    cmd.res  = res_sel;
    case (state)
      S_IDLE:  if (req_valid) cmd.op = DP_START;
      S_XPOLY: begin
        cmd.op = (ph == 2'd0) ? DP_LOAD : DP_MAC;
        case (ph)
          2'd0:    cmd.coef = CF_AX;
          2'd1:    cmd.coef = CF_BX;
          2'd2:    cmd.coef = CF_CX;
          default: cmd.coef = CF_ZERO;
        endcase
      end
      S_DPOLY: begin
        cmd.op = (ph == 2'd0) ? DP_LOAD : DP_MAC;
        case (ph)
          2'd0:    cmd.coef = CF_AX3;
          2'd1:    cmd.coef = CF_BX2;
          default: cmd.coef = CF_CX;
        endcase
      end
      S_YPOLY: begin
        cmd.op = (ph == 2'd0) ? DP_LOAD : DP_MAC;
        case (ph)
          2'd0:    cmd.coef = CF_AY;
          2'd1:    cmd.coef = CF_BY;
          2'd2:    cmd.coef = CF_CY;
          default: cmd.coef = CF_ZERO;
        endcase
      end
      S_XERR:  cmd.op = DP_ERR;
      S_DIVI:  cmd.op = DP_DIV_INIT;
      S_DIVS:  cmd.op = DP_DIV_STEP;
      S_NUPD:  cmd.op = DP_NEWTON_UPD;
      S_BINIT: cmd.op = DP_BIS_INIT;
      S_BUPD:  cmd.op = DP_BIS_UPD;
      S_FIN:   if (stat.out_free) cmd.op = DP_FINISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ph      <= '0;
      ni      <= '0;
      bi      <= '0;
      dc      <= '0;
      bis     <= 1'b0;
      res_sel <= RES_ZERO;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_ENDS;
            ph    <= '0;
            ni    <= '0;
            bis   <= 1'b0;
          end
        end
        S_ENDS: begin
          if (stat.t_zero) begin
            res_sel <= RES_ZERO;
            state   <= S_FIN;
          end else if (stat.t_one) begin
            res_sel <= RES_ONE;
            state   <= S_FIN;
          end else begin
            state <= S_XPOLY;
          end
        end
        S_XPOLY: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            ph    <= '0;
            state <= S_XERR;
          end
        end
        S_XERR:  state <= bis ? S_BCHK : S_NCHK;
        S_NCHK:  state <= stat.err_small_n ? S_YPOLY : S_DPOLY;
        S_DPOLY: begin
          ph <= ph + 2'd1;
          if (ph == 2'd2) begin
            ph    <= '0;
            state <= S_DCHK;
          end
        end
        // flat slope gives up on newton
        S_DCHK:  state <= stat.acc_small ? S_BINIT : S_DIVI;
        S_DIVI: begin
          dc    <= '0;
          state <= S_DIVS;
        end
        S_DIVS: begin
          dc <= dc + 1'b1;
          if (dc == DCW'(SW - 1)) state <= S_NUPD;
        end
        S_NUPD: begin
          ni <= ni + 1'b1;
          if (ni == NIW'(NEWTON_STEPS - 1)) state <= S_BINIT;
          else state <= S_XPOLY;
        end
        S_BINIT: begin
          bis   <= 1'b1;
          bi    <= '0;
          state <= S_BLOOP;
        end
        S_BLOOP: begin
          if (bi < BIW'(BISECT_STEPS) && stat.lo_lt_hi) state <= S_XPOLY;
          else state <= S_YPOLY;
        end
        S_BCHK:  state <= stat.err_small_b ? S_YPOLY : S_BUPD;
        S_BUPD: begin
          bi    <= bi + 1'b1;
          state <= S_BLOOP;
        end
        S_YPOLY: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            ph      <= '0;
            res_sel <= RES_ACC;
            state   <= S_FIN;
          end
        end
        S_FIN:   if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/cubic_bezier_easing_top.sv */
// cubic_bezier_easing_top: CSS-style cubic Bezier easing, y at x = progress.
// Depends on cbe_pkg, cbe_if, cbe_ctrl and cbe_datapath.
//
// Channels: req carries progress (17 bits, 16 fraction bits by default),
// rsp carries eased (19 bits signed), cfg writes the control points
// x1, y1, x2, y2 at indexes 0 to 3 and is always ready; write it only
// while no transaction is in flight.
// One item is solved at a time. Progress of zero or at/above 1.0 skips
// the solver. Otherwise each Newton step evaluates x(s) and its slope
// and runs the bit-serial divider, which dominates it; each bisection
// step evaluates x(s) and halves the bounds, and the final y polynomial follows.
// All products go through one rounding multiplier working on the curve
// parameter, one product per cycle.
// Reset restores the default control points and drops any pending result.
// The result sits in an output register; a new transaction is accepted
// while it waits, and the solver only holds if a second result is ready
// before the first has been taken.
module cubic_bezier_easing_top #(
  parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF,
  parameter int FRAC_BITS    = cbe_pkg::FRAC_BITS_DEF,
  parameter int BISECT_STEPS = cbe_pkg::BISECT_STEPS_DEF
) (
  input logic      clk,
  input logic      rst,
  cbe_req_if.sink  req,
  cbe_rsp_if.source rsp,
  cbe_cfg_if.sink  cfg
);
  import cbe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  cbe_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS),
    .FRAC_BITS    (FRAC_BITS),
    .BISECT_STEPS (BISECT_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .progress  (req.progress),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .eased     (rsp.eased)
  );

endmodule

/* hdl/cbe_checker.sv */
// cbe_checker: port-level checks for the easing block, bound to the top.
// Depends on cbe_pkg and cubic_bezier_easing_top.
module cbe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [cbe_pkg::OUT_W-1:0]  eased
);
  import cbe_pkg::*;

  // a result waiting for the sink is not withdrawn
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(eased))
    else $error("rsp payload changed while stalled");

  // one item in the solver at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req accepted while solver busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("pending result survived reset");

endmodule

bind cubic_bezier_easing_top cbe_checker u_cbe_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .eased     (rsp.eased)
);

/* tb/sv/cubic_bezier_easing_top_test.sv */
// cubic_bezier_easing_top_test: drives progress values and control point writes
// into the easing block and checks every eased result against a fixed-point predictor.
// Depends on cbe_pkg, cbe_if and cubic_bezier_easing_top.
module cubic_bezier_easing_top_test;
  import cbe_pkg::*;

  localparam longint ONE_Q = 64'sd65536;
  localparam int LIMIT = 3000000;

  logic clk;
  logic rst;
  cbe_req_if req ();
  cbe_rsp_if rsp ();
  cbe_cfg_if cfg ();

  cubic_bezier_easing_top uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  logic [XREG_W-1:0] cur_x1, cur_x2;
  logic [YREG_W-1:0] cur_y1, cur_y2;
  logic signed [OUT_W-1:0] eased_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int take_stall = 0;
  int hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // rounded product, ties toward plus infinity
  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint cubic(longint a, longint b, longint c, longint s);
    return qmul(qmul(qmul(a, s) + b, s) + c, s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] ease_of(logic [PROG_W-1:0] prog);
    longint t, x1, x2, y1, y2, cx, bx, ax, cy, by, ay, s, y, lo, hi, err, d, xe;
    bit done;
    t = prog;
    x1 = clip(cur_x1, 0, ONE_Q);
    x2 = clip(cur_x2, 0, ONE_Q);
    y1 = longint'($signed(cur_y1));
    y2 = longint'($signed(cur_y2));
    done = 0;
    y = 0;
    if (t == 0) done = 1;
    else if (t >= ONE_Q) begin
      y = ONE_Q;
      done = 1;
    end
    cx = 3 * x1;
    bx = 3 * (x2 - x1) - cx;
    ax = ONE_Q - cx - bx;
    cy = 3 * y1;
    by = 3 * (y2 - y1) - cy;
    ay = ONE_Q - cy - by;
    s = t;
    // newton tolerance is one lsb: only an exact hit passes
    for (int i = 0; !done && i < NEWTON_STEPS_DEF; i++) begin
      err = cubic(ax, bx, cx, s) - t;
      if (mag(err) < 1) begin
        y = cubic(ay, by, cy, s);
        done = 1;
        break;
      end
      d = qmul(qmul(3 * ax, s) + 2 * bx, s) + cx;
      if (mag(d) < 1) break;
      s = clip(s - (err * ONE_Q) / d, 0, ONE_Q);
    end
    if (!done) begin
      lo = 0;
      hi = ONE_Q;
      s = t;
      for (int i = 0; i < BISECT_STEPS_DEF && lo < hi; i++) begin
        xe = cubic(ax, bx, cx, s);
        if (mag(xe - t) < 7) break;
        if (t > xe) lo = s;
        else hi = s;
        s = (lo + hi) >>> 1;
      end
      y = cubic(ay, by, cy, s);
    end
    return OUT_W'(clip(y, -262144, 262143));
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (eased_q.size() == 0) report("unexpected eased", rsp.eased, 0);
      else begin
        if (rsp.eased !== eased_q[0]) report("eased", rsp.eased, eased_q[0]);
        void'(eased_q.pop_front());
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else
      rsp.ready <= ($urandom_range(99) >= take_stall);
  end

  // valid stays up after a transaction so items can follow back to back
  task automatic send_progress(logic [PROG_W-1:0] prog);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.progress <= prog;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    eased_q.push_back(ease_of(prog));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_X1: cur_x1 = val[XREG_W-1:0];
      REG_Y1: cur_y1 = val;
      REG_X2: cur_x2 = val[XREG_W-1:0];
      default: cur_y2 = val;
    endcase
  endtask

  task automatic set_curve(int x1, int y1, int x2, int y2);
    write_reg(REG_X1, CFG_DATA_W'(x1));
    write_reg(REG_Y1, CFG_DATA_W'(y1));
    write_reg(REG_X2, CFG_DATA_W'(x2));
    write_reg(REG_Y2, CFG_DATA_W'(y2));
    cfg.valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [PROG_W-1:0] pts[$] = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd65537,
      17'h1FFFF, 17'd32768, 17'd16384, 17'd49152, 17'h0AAAA, 17'h15555};
    foreach (pts[i]) send_progress(pts[i]);
    drain();
    // flat slope in the middle of the curve can force the bisection
    set_curve(65536, 0, 0, 65536);
    foreach (pts[i]) send_progress(pts[i]);
    drain();
    // x above 1.0 saturates, y control points lie far outside 0 to 1.0
    set_curve(131071, 131072, 131071, -131072);
    send_progress(17'd32768);
    send_progress(17'd100);
    send_progress(17'd65000);
    drain();
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle = idle;
    take_stall = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_progress(PROG_W'($urandom_range(3) == 0 ? 65536 + $urandom_range(65535) : 0));
      else send_progress(PROG_W'($urandom_range(65536)));
    end
    drain();
  endtask

  task automatic test_random_curves();
    for (int k = 0; k < 5; k++) begin
      set_curve($urandom_range(65536), int'($urandom_range(262143)) - 131072,
                $urandom_range(65536), int'($urandom_range(262143)) - 131072);
      random_phase(25, 0, 0);
      random_phase(25, 80, 0);
      random_phase(25, 0, 80);
      random_phase(25, 34, 34);
    end
    // full raw register values
    set_curve($urandom_range(131071), $urandom_range(524287),
              $urandom_range(131071), $urandom_range(524287));
    random_phase(30, 0, 0);
  endtask

  task automatic test_backpressure();
    set_curve(16384, 6554, 16384, 65536);
    take_stall = 0;
    send_idle = 0;
    hold_off = 2000;
    for (int i = 0; i < 10; i++) send_progress(PROG_W'($urandom_range(1, 65535)));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.progress = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    cur_x1 = X1_RST;
    cur_y1 = Y1_RST;
    cur_x2 = X2_RST;
    cur_y2 = Y2_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_curves();
    test_backpressure();
    repeat (50) @(posedge clk);
    if (errors == 0 && eased_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

/* cubic_bezier_easing_top.f */
hdl/cbe_pkg.sv
hdl/cbe_if.sv
hdl/cbe_datapath.sv
hdl/cbe_ctrl.sv
hdl/cubic_bezier_easing_top.sv
hdl/cbe_checker.sv
tb/sv/cubic_bezier_easing_top_test.sv
